// File: rtl/tajb_pkg.sv
package tajb_pkg;

	localparam int DEPTH_DEF       = 1024;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int ID_W            = 48;
	localparam int VAL_W           = 16;
	localparam int GAIN_W          = 16;
	localparam int FRAC_BITS       = 12;
	localparam int FIFO_DEPTH      = 2;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic {
		BK_RUN,
		BK_FILL
	} back_state_t;

	// Register indexes on the configuration channel.
	typedef enum logic {
		REG_SOURCE_CH = 1'b0,
		REG_OUTPUT_CH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t                      op;
		logic [ID_W-1:0]          frame_id;
		logic signed [VAL_W-1:0]  v0;
		logic signed [VAL_W-1:0]  v1;
		logic [GAIN_W-1:0]        gain;
		logic                     last;
	} item_t;

	// Channel settings after clamping: a value of 0 acts as 1, a value of 3 as 2.
	typedef struct packed {
		logic two_src;
		logic two_out;
	} chan_cfg_t;

endpackage

// File: rtl/timestamped_audio_jitter_buffer.sv
// A read beat leaves the queue into the store read stage, then passes the sum stage and
// the output registers; done marks its result on the outputs.
// Throughput: one beat per cycle, except that a write which opens a gap holds the back
// end while a zero frame is stored for each missing frame; busy rises once full.
// Reset: arst_n clears the window, the queue and the pipeline; registers return
// to two channels. The frame store is not cleared, and the receiver cannot stall.
module timestamped_audio_jitter_buffer #(
	parameter int DEPTH       = tajb_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = tajb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                req_type,
	input  logic [tajb_pkg::ID_W-1:0]           frame_id,
	input  logic signed [tajb_pkg::VAL_W-1:0]   value_ch0,
	input  logic signed [tajb_pkg::VAL_W-1:0]   value_ch1,
	input  logic [tajb_pkg::GAIN_W-1:0]         gain,
	input  logic                                last_frame,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [1:0]                          cfg_data,
	output logic                                done,
	output logic signed [tajb_pkg::VAL_W-1:0]   out_ch0,
	output logic signed [tajb_pkg::VAL_W-1:0]   out_ch1,
	output logic                                in_window,
	output logic                                last_out
);

	// The configuration registers keep the raw two-bit values; only the top bit
	// matters after clamping, since 0 and 1 mean one channel, 2 and 3 mean two.
	logic [1:0]           src_ch_q;
	logic [1:0]           out_ch_q;
	tajb_pkg::chan_cfg_t  cfg;
	tajb_pkg::item_t      in_item;
	tajb_pkg::item_t      head_item;
	logic                 full;
	logic                 avail;
	logic                 pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch_q <= 2'd2;
			out_ch_q <= 2'd2;
		end else if (cfg_valid) begin
			case (tajb_pkg::reg_idx_t'(cfg_index))
				tajb_pkg::REG_SOURCE_CH: src_ch_q <= cfg_data;
				tajb_pkg::REG_OUTPUT_CH: out_ch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.two_src = src_ch_q[1];
	assign cfg.two_out = out_ch_q[1];

	// The front end decodes the request into an operation and queues it, so the caller
	// can keep streaming until the queue is full while the back end fills a gap.
	assign in_item.op        = req_type ? tajb_pkg::OP_READ : tajb_pkg::OP_WRITE;
	assign in_item.frame_id  = frame_id;
	assign in_item.v0        = value_ch0;
	assign in_item.v1        = value_ch1;
	assign in_item.gain      = gain;
	assign in_item.last      = last_frame;

	assign busy = full;

	tajb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (start),
		.push_item (in_item),
		.full      (full),
		.pop       (pop),
		.avail     (avail),
		.head_item (head_item)
	);

	// The back end owns the window and the frame store, and runs the mix
	// pipeline: store read, multiply and add, then round and saturate.
	tajb_back #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.avail     (avail),
		.item      (head_item),
		.pop       (pop),
		.done      (done),
		.out_ch0   (out_ch0),
		.out_ch1   (out_ch1),
		.in_window (in_window),
		.last_out  (last_out)
	);

endmodule

// File: rtl/tajb_front.sv
module tajb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tajb_pkg::item_t     push_item,
	output logic                full,
	input  logic                pop,
	output logic                avail,
	output tajb_pkg::item_t     head_item
);

	localparam int PW = $clog2(tajb_pkg::FIFO_DEPTH);

	tajb_pkg::item_t   fifo_q [tajb_pkg::FIFO_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (cnt_q == (PW+1)'(tajb_pkg::FIFO_DEPTH));
	assign avail     = (cnt_q != '0);
	assign head_item = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/tajb_back.sv
module tajb_back #(
	parameter int DEPTH       = tajb_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = tajb_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tajb_pkg::chan_cfg_t               cfg,
	input  logic                              avail,
	input  tajb_pkg::item_t                   item,
	output logic                              pop,
	output logic                              done,
	output logic signed [tajb_pkg::VAL_W-1:0] out_ch0,
	output logic signed [tajb_pkg::VAL_W-1:0] out_ch1,
	output logic                              in_window,
	output logic                              last_out
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = AW + 1;
	localparam int IW   = tajb_pkg::ID_W;
	localparam int VW   = tajb_pkg::VAL_W;
	localparam int TW   = 35;
	localparam int RW   = TW - tajb_pkg::FRAC_BITS;
	localparam int SW   = 34;
	localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (SAMPLE_BITS - 1)) - SW'(1);
	localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (SAMPLE_BITS - 1));
	localparam logic signed [TW-1:0] ROUND  = TW'(1) <<< (tajb_pkg::FRAC_BITS - 1);

	tajb_pkg::back_state_t state_q, state_d;

	logic [2*VW-1:0] mem [DEPTH];

	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic [IW-1:0]  base_q;
	logic           wvalid_q;
	logic [CW-1:0]  gap_q;
	logic [2*VW-1:0] frame_q;

	logic [IW-1:0]  diff;
	logic [IW-1:0]  ahead;
	logic           behind;
	logic           is_read, is_write;
	logic           restart, stale, hit;
	logic           app_en, app_restart;
	logic [2*VW-1:0] app_data;
	logic [CW-1:0]  gap_d;
	logic [CW:0]    wsum, rsum;
	logic [AW-1:0]  wslot, rslot;
	logic [AW-1:0]  head_b;
	logic [CW-1:0]  count_b;
	logic [IW-1:0]  base_b;

	// Read stage one: memory data and item fields.
	logic                 v_s1, hit_s1, two_src_s1, two_out_s1, last_s1;
	logic signed [VW-1:0] m0_s1, m1_s1;
	logic [tajb_pkg::GAIN_W-1:0] gain_s1;
	logic [2*VW-1:0]      rd_s1;
	// Read stage two: the sums before rounding shift.
	logic                 v_s2, hit_s2, use1_s2, last_s2;
	logic signed [VW-1:0] m0_s2, m1_s2;
	logic signed [TW-1:0] t0_s2, t1_s2;

	logic signed [VW-1:0] smp0, smp1;
	logic signed [RW-1:0] r0, r1;

	assign is_read  = avail && (state_q == tajb_pkg::BK_RUN) && (item.op == tajb_pkg::OP_READ);
	assign is_write = avail && (state_q == tajb_pkg::BK_RUN) && (item.op == tajb_pkg::OP_WRITE);
	assign pop      = avail && (state_q == tajb_pkg::BK_RUN);

	assign diff    = item.frame_id - base_q;
	assign behind  = diff[IW-1];
	assign ahead   = diff - IW'(count_q);
	assign hit     = wvalid_q && !behind && (diff < IW'(count_q));
	assign restart = !wvalid_q || (!behind && (diff >= IW'(count_q)) && (ahead >= IW'(DEPTH)));
	assign stale   = behind || (diff < IW'(count_q));

	// Append position, with the base already moved for a restart.
	always_comb begin
		head_b  = head_q;
		count_b = count_q;
		base_b  = base_q;
		if (app_restart) begin
			head_b  = '0;
			count_b = '0;
			base_b  = item.frame_id;
		end
	end

	assign wsum  = {1'b0, CW'(head_b)} + {1'b0, count_b};
	assign wslot = (wsum >= (CW+1)'(DEPTH)) ? AW'(wsum - (CW+1)'(DEPTH)) : AW'(wsum);
	assign rsum  = {1'b0, CW'(head_q)} + {1'b0, diff[CW-1:0]};
	assign rslot = (rsum >= (CW+1)'(DEPTH)) ? AW'(rsum - (CW+1)'(DEPTH)) : AW'(rsum);

	always_comb begin
		state_d     = state_q;
		app_en      = 1'b0;
		app_restart = 1'b0;
		app_data    = {item.v1, item.v0};
		gap_d       = gap_q;
		case (state_q)
			tajb_pkg::BK_RUN: begin
				if (is_write) begin
					if (restart) begin
						app_en      = 1'b1;
						app_restart = 1'b1;
					end else if (!stale) begin
						app_en = 1'b1;
						if (ahead[CW-1:0] != '0) begin
							app_data = '0;
							gap_d    = ahead[CW-1:0] - 1'b1;
							state_d  = tajb_pkg::BK_FILL;
						end
					end
				end
			end
			tajb_pkg::BK_FILL: begin
				app_en = 1'b1;
				if (gap_q == '0) begin
					app_data = frame_q;
					state_d  = tajb_pkg::BK_RUN;
				end else begin
					app_data = '0;
					gap_d    = gap_q - 1'b1;
				end
			end
			default: state_d = tajb_pkg::BK_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tajb_pkg::BK_RUN;
			head_q   <= '0;
			count_q  <= '0;
			base_q   <= '0;
			wvalid_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			done     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (app_en) begin
				wvalid_q <= 1'b1;
				if (count_b < CW'(DEPTH)) begin
					head_q  <= head_b;
					count_q <= count_b + 1'b1;
					base_q  <= base_b;
				end else begin
					head_q  <= (head_b == AW'(DEPTH - 1)) ? '0 : head_b + 1'b1;
					count_q <= count_b;
					base_q  <= base_b + 1'b1;
				end
			end
			v_s1 <= is_read;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		gap_q <= gap_d;
		if (is_write) begin
			frame_q <= {item.v1, item.v0};
		end
		if (app_en) begin
			mem[wslot] <= app_data;
		end
		if (is_read) begin
			rd_s1 <= mem[rslot];
		end
	end

	// Read pipeline payload.
	always_ff @(posedge clk) begin
		hit_s1     <= hit;
		two_src_s1 <= cfg.two_src;
		two_out_s1 <= cfg.two_out;
		last_s1    <= item.last;
		m0_s1      <= item.v0;
		m1_s1      <= item.v1;
		gain_s1    <= item.gain;

		hit_s2  <= hit_s1;
		use1_s2 <= two_out_s1;
		last_s2 <= last_s1;
		m0_s2   <= m0_s1;
		m1_s2   <= m1_s1;
		t0_s2   <= (TW'(m0_s1) <<< tajb_pkg::FRAC_BITS)
			+ TW'($signed({1'b0, gain_s1}) * smp0) + ROUND;
		t1_s2   <= (TW'(m1_s1) <<< tajb_pkg::FRAC_BITS)
			+ TW'($signed({1'b0, gain_s1}) * smp1) + ROUND;
	end

	assign smp0 = $signed(rd_s1[VW-1:0]);
	assign smp1 = two_src_s1 ? $signed(rd_s1[2*VW-1:VW]) : $signed(rd_s1[VW-1:0]);

	assign r0 = RW'(t0_s2 >>> tajb_pkg::FRAC_BITS);
	assign r1 = RW'(t1_s2 >>> tajb_pkg::FRAC_BITS);

	function automatic logic signed [VW-1:0] sat(input logic signed [RW-1:0] r);
		logic signed [SW-1:0] x;
		x = SW'(r);
		if (x > SAT_HI) begin
			x = SAT_HI;
		end else if (x < SAT_LO) begin
			x = SAT_LO;
		end
		return x[VW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (v_s2) begin
			in_window <= hit_s2;
			last_out  <= last_s2;
			out_ch0   <= hit_s2 ? sat(r0) : m0_s2;
			out_ch1   <= (hit_s2 && use1_s2) ? sat(r1) : m1_s2;
		end
	end

endmodule
